// ===== rtl/core/detection_head_decode_core_defines.svh =====
// Assertion macros shared by the detection head decode RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef DETECTION_HEAD_DECODE_CORE_DEFINES_SVH
`define DETECTION_HEAD_DECODE_CORE_DEFINES_SVH

// same-cycle implication
`define DHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dhd_pkg.sv =====
// Package for the detection head decode block: widths, register codes,
// configuration and row record types. No dependencies.
package dhd_pkg;

    localparam int ValueWidth    = 24;
    localparam int ClassWidth    = 7;
    localparam int MaxClasses    = 128;
    localparam int PosWidth      = 8;
    localparam int BoxWidth      = 16;
    localparam int PadWidth      = 12;
    localparam int MaskWidth     = 128;
    localparam int RegIndexWidth = 3;
    localparam int CfgDataWidth  = 64;
    localparam int BoxAttrs      = 4;

    typedef enum logic [RegIndexWidth-1:0] {
        RegConfThreshold = 3'd0,
        RegInvScale      = 3'd1,
        RegPadX          = 3'd2,
        RegPadY          = 3'd3,
        RegFilterEnable  = 3'd4,
        RegAllowMaskLow  = 3'd5,
        RegAllowMaskHigh = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [ValueWidth-1:0] conf_threshold;
        logic [ValueWidth-1:0] inv_scale;
        logic [PadWidth-1:0]   pad_x;
        logic [PadWidth-1:0]   pad_y;
        logic                  filter_enable;
        logic [MaskWidth-1:0]  allow_mask;
    } cfg_t;

    typedef struct packed {
        logic [ValueWidth-1:0] cx;
        logic [ValueWidth-1:0] cy;
        logic [ValueWidth-1:0] w;
        logic [ValueWidth-1:0] h;
        logic [ValueWidth-1:0] score;
        logic [ClassWidth-1:0] class_index;
        logic                  found;
    } row_rec_t;

endpackage

// ===== rtl/core/dhd_ifs.sv =====
// Stream interfaces for the detection head decode block: row words in,
// detection words out. Depends on dhd_pkg.
interface dhd_in_if
    import dhd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ValueWidth-1:0] attr_value;
    logic                  row_last;

    modport source (output valid, attr_value, row_last, input ready);
    modport sink   (input valid, attr_value, row_last, output ready);
endinterface

interface dhd_out_if
    import dhd_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [BoxWidth-1:0]  box_x;
    logic signed [BoxWidth-1:0]  box_y;
    logic [BoxWidth-1:0]         box_width;
    logic [BoxWidth-1:0]         box_height;
    logic [ValueWidth-1:0]       confidence;
    logic [ClassWidth-1:0]       class_index;

    modport source (output valid, box_x, box_y, box_width, box_height, confidence,
                    class_index, input ready);
    modport sink   (input valid, box_x, box_y, box_width, box_height, confidence,
                    class_index, output ready);
endinterface

// ===== rtl/core/detection_head_decode_core.sv =====
// Top level of the detection head decode block.
// Depends on dhd_pkg, dhd_ifs, dhd_cfg_regs, dhd_row_argmax, dhd_box_decode.

// Takes one row word per cycle while ready is high (cx, cy, w, h, then
// class scores, last one marked) and gives at most one detection word per
// row. The marked word loads the row record register, from which the
// record passes through the stage registers below to the output register.
// Stages: row record, keep decision and letterbox offset, inv_scale
// multiply, rounding and saturation. Ready drops only when the row record
// register is full and the pipeline behind it is stalled. Write
// configuration only while no row is in flight.
module detection_head_decode_core
    import dhd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    dhd_in_if.sink                   row,
    dhd_out_if.source                box,
    input  logic                     write_enable,
    input  logic [RegIndexWidth-1:0] reg_index,
    input  logic [CfgDataWidth-1:0]  write_data
);

    cfg_t     cfg;
    row_rec_t rec;
    logic     rec_valid;
    logic     rec_ready;

    dhd_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .cfg          (cfg)
    );

    dhd_row_argmax u_row_argmax (
        .clk       (clk),
        .rst_n     (rst_n),
        .row       (row),
        .rec       (rec),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready)
    );

    dhd_box_decode u_box_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rec       (rec),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .box       (box)
    );

endmodule

// ===== rtl/core/dhd_cfg_regs.sv =====
// Configuration register file of the detection head decode block.
// Depends on dhd_pkg.
module dhd_cfg_regs
    import dhd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     write_enable,
    input  logic [RegIndexWidth-1:0] reg_index,
    input  logic [CfgDataWidth-1:0]  write_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (reg_index_t'(reg_index))
                RegConfThreshold: cfg_next.conf_threshold = write_data[ValueWidth-1:0];
                RegInvScale:      cfg_next.inv_scale      = write_data[ValueWidth-1:0];
                RegPadX:          cfg_next.pad_x          = write_data[PadWidth-1:0];
                RegPadY:          cfg_next.pad_y          = write_data[PadWidth-1:0];
                RegFilterEnable:  cfg_next.filter_enable  = write_data[0];
                RegAllowMaskLow:  cfg_next.allow_mask[CfgDataWidth-1:0] = write_data;
                RegAllowMaskHigh: cfg_next.allow_mask[MaskWidth-1:CfgDataWidth] = write_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_threshold <= ValueWidth'(1024);
            cfg_reg.inv_scale      <= ValueWidth'(65536);
            cfg_reg.pad_x          <= '0;
            cfg_reg.pad_y          <= '0;
            cfg_reg.filter_enable  <= 1'b0;
            cfg_reg.allow_mask     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/dhd_row_argmax.sv =====
// Row intake: stores the four box attributes and keeps the running argmax
// over class scores; emits one row record per marked word. Depends on dhd_pkg.
`include "detection_head_decode_core_defines.svh"

module dhd_row_argmax
    import dhd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dhd_in_if.sink   row,
    output row_rec_t rec,
    output logic     rec_valid,
    input  logic     rec_ready
);

    logic [PosWidth-1:0]   position_reg;
    logic [PosWidth-1:0]   position_next;
    logic [ValueWidth-1:0] attr_reg [BoxAttrs];
    logic [ValueWidth-1:0] attr_next [BoxAttrs];
    logic [ValueWidth-1:0] best_score_reg;
    logic [ValueWidth-1:0] best_score_next;
    logic [ClassWidth-1:0] best_class_reg;
    logic [ClassWidth-1:0] best_class_next;
    logic                  best_found_reg;
    logic                  best_found_next;
    row_rec_t              rec_reg;
    logic                  rec_valid_reg;

    logic                  accept;
    logic                  is_attr;
    logic [PosWidth-1:0]   class_pos;
    logic                  take;

    assign row.ready = !rec_valid_reg || rec_ready;
    assign accept    = row.valid && row.ready;
    assign is_attr   = (position_reg < PosWidth'(BoxAttrs));
    assign class_pos = position_reg - PosWidth'(BoxAttrs);
    assign take      = !is_attr && (class_pos < PosWidth'(MaxClasses))
                       && (row.attr_value > best_score_reg);

    always_comb
    begin
        for (int i = 0; i < BoxAttrs; i++)
        begin
            attr_next[i] = attr_reg[i];
        end
        if (is_attr)
        begin
            attr_next[position_reg[1:0]] = row.attr_value;
        end

        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        best_found_next = best_found_reg;
        if (take)
        begin
            best_score_next = row.attr_value;
            best_class_next = class_pos[ClassWidth-1:0];
            best_found_next = 1'b1;
        end

        position_next = (position_reg == '1) ? position_reg : position_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < BoxAttrs; i++)
            begin
                attr_reg[i] <= attr_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            best_score_reg <= '0;
            best_class_reg <= '0;
            best_found_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (row.row_last)
            begin
                position_reg   <= '0;
                best_score_reg <= '0;
                best_class_reg <= '0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                position_reg   <= position_next;
                best_score_reg <= best_score_next;
                best_class_reg <= best_class_next;
                best_found_reg <= best_found_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
        end
        else if (accept && row.row_last)
        begin
            rec_valid_reg <= 1'b1;
        end
        else if (rec_ready)
        begin
            rec_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && row.row_last)
        begin
            rec_reg.cx          <= attr_next[0];
            rec_reg.cy          <= attr_next[1];
            rec_reg.w           <= attr_next[2];
            rec_reg.h           <= attr_next[3];
            rec_reg.score       <= best_score_next;
            rec_reg.class_index <= best_class_next;
            rec_reg.found       <= best_found_next;
        end
    end

    assign rec       = rec_reg;
    assign rec_valid = rec_valid_reg;

    `DHD_ASSERT_NEXT(a_row_end_clears, accept && row.row_last,
        position_reg == '0 && !best_found_reg, "row state not cleared after row end")
    `DHD_ASSERT_NOW(a_no_class_no_score, !best_found_reg,
        best_score_reg == '0, "score held without a class")
    `DHD_ASSERT_NOW(a_attrs_before_class, position_reg <= PosWidth'(BoxAttrs),
        !best_found_reg, "class found while box attributes still arriving")

endmodule

// ===== rtl/core/dhd_box_decode.sv =====
// Box decode pipeline: keep decision and letterbox offset, scaling multiply,
// rounding and saturation into the output register. Depends on dhd_pkg.
`include "detection_head_decode_core_defines.svh"

module dhd_box_decode
    import dhd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  row_rec_t rec,
    input  logic     rec_valid,
    output logic     rec_ready,
    dhd_out_if.source box
);

    localparam int EdgeWidth  = ValueWidth + 3;
    localparam int MagWidth   = EdgeWidth - 1;
    localparam int EdgeProdW  = MagWidth + ValueWidth;
    localparam int ExtProdW   = 2 * ValueWidth;
    localparam int EdgeShift  = 29;
    localparam int ExtShift   = 28;
    localparam int EdgeRoundW = EdgeProdW + 1 - EdgeShift;
    localparam int ExtRoundW  = ExtProdW + 1 - ExtShift;

    typedef struct packed {
        logic                  neg;
        logic [MagWidth-1:0]   mag;
    } edge_t;

    function automatic edge_t offset_edge(input logic [ValueWidth-1:0] centre,
                                          input logic [ValueWidth-1:0] size,
                                          input logic [PadWidth-1:0]   pad);
        logic signed [EdgeWidth-1:0] q;
        edge_t                       e;
        q = $signed({2'b00, centre, 1'b0}) - $signed({3'b000, size})
            - $signed({2'b00, pad, 13'b0});
        e.neg = q[EdgeWidth-1];
        e.mag = e.neg ? MagWidth'(-q) : q[MagWidth-1:0];
        return e;
    endfunction

    function automatic logic [BoxWidth-1:0] round_edge(input logic                 neg,
                                                       input logic [EdgeProdW-1:0] prod);
        logic [EdgeProdW:0]    sum;
        logic [EdgeRoundW-1:0] r;
        logic [BoxWidth-1:0]   res;
        sum = {1'b0, prod} + ((EdgeProdW + 1)'(1) << (EdgeShift - 1));
        r   = sum[EdgeProdW:EdgeShift];
        if (neg)
        begin
            res = (r >= EdgeRoundW'(32768)) ? 16'h8000 : BoxWidth'(-r[BoxWidth-1:0]);
        end
        else
        begin
            res = (r > EdgeRoundW'(32767)) ? 16'h7FFF : r[BoxWidth-1:0];
        end
        return res;
    endfunction

    function automatic logic [BoxWidth-1:0] round_extent(input logic [ExtProdW-1:0] prod);
        logic [ExtProdW:0]    sum;
        logic [ExtRoundW-1:0] r;
        sum = {1'b0, prod} + ((ExtProdW + 1)'(1) << (ExtShift - 1));
        r   = sum[ExtProdW:ExtShift];
        return (r > ExtRoundW'(65535)) ? 16'hFFFF : r[BoxWidth-1:0];
    endfunction

    logic                  keep;
    edge_t                 edge_x;
    edge_t                 edge_y;

    logic                  s1_valid_reg;
    logic                  s1_ready;
    edge_t                 s1_x_reg;
    edge_t                 s1_y_reg;
    logic [ValueWidth-1:0] s1_w_reg;
    logic [ValueWidth-1:0] s1_h_reg;
    logic [ValueWidth-1:0] s1_score_reg;
    logic [ClassWidth-1:0] s1_class_reg;

    logic                  s2_valid_reg;
    logic                  s2_ready;
    logic                  s2_neg_x_reg;
    logic                  s2_neg_y_reg;
    logic [EdgeProdW-1:0]  s2_prod_x_reg;
    logic [EdgeProdW-1:0]  s2_prod_y_reg;
    logic [ExtProdW-1:0]   s2_prod_w_reg;
    logic [ExtProdW-1:0]   s2_prod_h_reg;
    logic [ValueWidth-1:0] s2_score_reg;
    logic [ClassWidth-1:0] s2_class_reg;

    logic                  out_valid_reg;
    logic                  out_ready;
    logic [BoxWidth-1:0]   out_x_reg;
    logic [BoxWidth-1:0]   out_y_reg;
    logic [BoxWidth-1:0]   out_w_reg;
    logic [BoxWidth-1:0]   out_h_reg;
    logic [ValueWidth-1:0] out_score_reg;
    logic [ClassWidth-1:0] out_class_reg;

    assign keep = rec.found && (rec.score >= cfg.conf_threshold)
                  && (!cfg.filter_enable || cfg.allow_mask[rec.class_index]);
    assign edge_x = offset_edge(rec.cx, rec.w, cfg.pad_x);
    assign edge_y = offset_edge(rec.cy, rec.h, cfg.pad_y);

    assign out_ready = !out_valid_reg || box.ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign rec_ready = s1_ready;

    // keep decision and letterbox offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= rec_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && rec_valid)
        begin
            s1_x_reg     <= edge_x;
            s1_y_reg     <= edge_y;
            s1_w_reg     <= rec.w;
            s1_h_reg     <= rec.h;
            s1_score_reg <= rec.score;
            s1_class_reg <= rec.class_index;
        end
    end

    // scale by inv_scale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_neg_x_reg  <= s1_x_reg.neg;
            s2_neg_y_reg  <= s1_y_reg.neg;
            s2_prod_x_reg <= EdgeProdW'(s1_x_reg.mag * cfg.inv_scale);
            s2_prod_y_reg <= EdgeProdW'(s1_y_reg.mag * cfg.inv_scale);
            s2_prod_w_reg <= ExtProdW'(s1_w_reg * cfg.inv_scale);
            s2_prod_h_reg <= ExtProdW'(s1_h_reg * cfg.inv_scale);
            s2_score_reg  <= s1_score_reg;
            s2_class_reg  <= s1_class_reg;
        end
    end

    // round, saturate and hold for the sink
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_x_reg     <= round_edge(s2_neg_x_reg, s2_prod_x_reg);
            out_y_reg     <= round_edge(s2_neg_y_reg, s2_prod_y_reg);
            out_w_reg     <= round_extent(s2_prod_w_reg);
            out_h_reg     <= round_extent(s2_prod_h_reg);
            out_score_reg <= s2_score_reg;
            out_class_reg <= s2_class_reg;
        end
    end

    assign box.valid       = out_valid_reg;
    assign box.box_x       = $signed(out_x_reg);
    assign box.box_y       = $signed(out_y_reg);
    assign box.box_width   = out_w_reg;
    assign box.box_height  = out_h_reg;
    assign box.confidence  = out_score_reg;
    assign box.class_index = out_class_reg;

    `DHD_ASSERT_NOW(a_kept_above_threshold, out_valid_reg,
        out_score_reg >= cfg.conf_threshold, "emitted word below threshold")
    `DHD_ASSERT_NEXT(a_stage_advance, s1_valid_reg && s2_ready,
        s2_valid_reg, "scaling stage lost a word")

endmodule

// ===== tb/detection_head_decode_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for detection_head_decode_core: streams anchor rows into the row channel
// and checks every detection word against a planned result or an in-bench row decoder.
// Depends on dhd_pkg, dhd_ifs and the detection_head_decode_core RTL.
module detection_head_decode_core_tb;
    import dhd_pkg::*;

    localparam int Px           = 4096;
    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 8;
    localparam int PhaseWords   = 190;
    localparam int NumPlanned   = 19;
    localparam int NumPhases    = 6;

    typedef struct packed {
        logic [BoxWidth-1:0]   box_x;
        logic [BoxWidth-1:0]   box_y;
        logic [BoxWidth-1:0]   box_width;
        logic [BoxWidth-1:0]   box_height;
        logic [ValueWidth-1:0] confidence;
        logic [ClassWidth-1:0] class_index;
    } detection_t;

    typedef struct packed {
        logic [ValueWidth-1:0] cx, cy, w, h;
        logic [8:0]            words;
        logic [8:0]            peak_class;
        logic [ValueWidth-1:0] peak;
        logic [ValueWidth-1:0] other;
        logic                  typed;
        logic                  emits;
        detection_t            fixed;
    } planned_row_t;

    function automatic logic [ValueWidth-1:0] px(input int n);
        return ValueWidth'(n * Px);
    endfunction

    // cx, cy, w, h, words, peak class, peak, other scores, typed, emits, detection
    localparam planned_row_t RowPlan [NumPlanned] = '{
        '{px(100), px(50), px(20), px(10), 9'd7, 9'd1, 24'h1000, 24'h0, 1'b1, 1'b1,
          '{16'd90, 16'd45, 16'd20, 16'd10, 24'h1000, 7'd1}},
        '{px(12), px(0), px(0), px(0), 9'd1, 9'd0, 24'h0, 24'h0, 1'b1, 1'b0, '0},
        '{px(12), px(12), px(4), px(4), 9'd2, 9'd0, 24'h0, 24'h0, 1'b1, 1'b0, '0},
        '{px(12), px(12), px(4), px(4), 9'd3, 9'd0, 24'h0, 24'h0, 1'b1, 1'b0, '0},
        '{px(12), px(12), px(4), px(4), 9'd4, 9'd0, 24'h0, 24'h0, 1'b1, 1'b0, '0},
        '{px(40), px(40), px(8), px(8), 9'd5, 9'd0, 24'h0, 24'h0, 1'b1, 1'b0, '0},
        '{px(40), px(40), px(8), px(8), 9'd6, 9'd1, 24'd1023, 24'd5, 1'b1, 1'b0, '0},
        '{px(200), px(200), px(8), px(6), 9'd7, 9'd2, 24'd1024, 24'd3, 1'b1, 1'b1,
          '{16'd196, 16'd197, 16'd8, 16'd6, 24'd1024, 7'd2}},
        '{px(64), px(64), px(16), px(16), 9'd8, 9'd3, 24'h2000, 24'h2000, 1'b1, 1'b1,
          '{16'd56, 16'd56, 16'd16, 16'd16, 24'h2000, 7'd0}},
        '{px(64), px(64), px(16), px(16), 9'd8, 9'd3, 24'h2001, 24'h2000, 1'b1, 1'b1,
          '{16'd56, 16'd56, 16'd16, 16'd16, 24'h2001, 7'd3}},
        '{24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 9'd5, 9'd0, 24'hFFFFFF, 24'h0, 1'b1, 1'b1,
          '{16'hF800, 16'hF800, 16'd4096, 16'd4096, 24'hFFFFFF, 7'd0}},
        '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 9'd5, 9'd0, 24'hFFFFFF, 24'h0,
          1'b0, 1'b0, '0},
        '{24'h0, 24'h0, px(1), px(3), 9'd5, 9'd0, 24'h1000, 24'h0, 1'b1, 1'b1,
          '{16'hFFFF, 16'hFFFE, 16'd1, 16'd3, 24'h1000, 7'd0}},
        '{px(2), px(1), 24'h800, 24'h7FF, 9'd5, 9'd0, 24'h1000, 24'h0, 1'b1, 1'b1,
          '{16'd2, 16'd1, 16'd1, 16'd0, 24'h1000, 7'd0}},
        '{px(30), px(40), px(20), px(40), 9'd132, 9'd127, 24'h3000, 24'h1000, 1'b1, 1'b1,
          '{16'd20, 16'd20, 16'd20, 16'd40, 24'h3000, 7'd127}},
        '{px(64), px(64), px(16), px(16), 9'd144, 9'd130, 24'hFFFFFF, 24'h800, 1'b1, 1'b1,
          '{16'd56, 16'd56, 16'd16, 16'd16, 24'h800, 7'd0}},
        '{px(30), px(40), px(20), px(40), 9'd304, 9'd250, 24'hFFFFFF, 24'h1800, 1'b1, 1'b1,
          '{16'd20, 16'd20, 16'd20, 16'd40, 24'h1800, 7'd0}},
        '{24'h123456, 24'h0ABCDE, 24'h00F00F, 24'h0F0F0F, 9'd6, 9'd1, 24'h4000, 24'h0,
          1'b0, 1'b0, '0},
        '{24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555, 9'd6, 9'd1, 24'hAAAAAA, 24'h555555,
          1'b0, 1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                     write_enable;
    logic [RegIndexWidth-1:0] reg_index;
    logic [CfgDataWidth-1:0]  write_data;
    logic                     sink_ready = 1'b0;

    dhd_in_if  row_if ();
    dhd_out_if box_if ();

    assign box_if.ready = sink_ready;

    detection_head_decode_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .row          (row_if),
        .box          (box_if),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    always #5 clk = ~clk;

    logic [ValueWidth-1:0] cfg_threshold = 24'd1024;
    logic [ValueWidth-1:0] cfg_inv_scale = 24'd65536;
    logic [PadWidth-1:0]   cfg_pad_x     = '0;
    logic [PadWidth-1:0]   cfg_pad_y     = '0;
    logic                  cfg_filter    = 1'b0;
    logic [MaskWidth-1:0]  cfg_allow     = '0;

    logic [PosWidth-1:0]   row_pos    = '0;
    logic [ValueWidth-1:0] box_attr [BoxAttrs];
    logic [ValueWidth-1:0] best_score = '0;
    logic [ClassWidth-1:0] best_class = '0;
    logic                  best_found = 1'b0;

    detection_t expected_boxes [$];
    detection_t oldest_box;
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         steady_run  = 1'b0;

    function automatic bit take_break();
        return !steady_run && $urandom_range(0, 99) < 9;
    endfunction

    // append one detection to the tail of the expected queue
    function automatic void queue_box(input detection_t b);
        expected_boxes = {expected_boxes, b};
    endfunction

    function automatic logic [BoxWidth-1:0] letterbox_edge(input logic [ValueWidth-1:0] centre,
                                                           input logic [ValueWidth-1:0] size,
                                                           input logic [PadWidth-1:0] pad);
        longint          offset;
        longint unsigned mag;
        longint unsigned rounded;
        offset  = longint'(centre) * 2 - longint'(size) - longint'(pad) * 8192;
        mag     = (offset < 0) ? -offset : offset;
        rounded = (mag * cfg_inv_scale + (64'd1 << 28)) >> 29;
        if (offset < 0)
        begin
            return BoxWidth'(64'd0 - ((rounded > 64'd32768) ? 64'd32768 : rounded));
        end
        return BoxWidth'((rounded > 64'd32767) ? 64'd32767 : rounded);
    endfunction

    function automatic logic [BoxWidth-1:0] scaled_extent(input logic [ValueWidth-1:0] size);
        longint unsigned prod;
        longint unsigned rounded;
        prod    = size;
        prod    = prod * cfg_inv_scale;
        rounded = (prod + (64'd1 << 27)) >> 28;
        return BoxWidth'((rounded > 64'd65535) ? 64'd65535 : rounded);
    endfunction

    // advance the row decoder by one word; return 1 when it yields a detection
    function automatic bit decode_word(input logic [ValueWidth-1:0] value, input bit last,
                                       output detection_t found);
        int cls;
        bit keep;
        found = '0;
        if (row_pos < BoxAttrs)
        begin
            box_attr[row_pos[1:0]] = value;
        end
        else
        begin
            cls = int'(row_pos) - BoxAttrs;
            if (cls < MaxClasses && value > best_score)
            begin
                best_score = value;
                best_class = ClassWidth'(cls);
                best_found = 1'b1;
            end
        end
        if (row_pos != '1)
        begin
            row_pos = row_pos + 1'b1;
        end
        if (!last)
        begin
            return 1'b0;
        end
        keep = best_found && best_score >= cfg_threshold;
        if (keep && cfg_filter && !cfg_allow[best_class])
        begin
            keep = 1'b0;
        end
        if (keep)
        begin
            found = '{letterbox_edge(box_attr[0], box_attr[2], cfg_pad_x),
                      letterbox_edge(box_attr[1], box_attr[3], cfg_pad_y),
                      scaled_extent(box_attr[2]), scaled_extent(box_attr[3]),
                      best_score, best_class};
        end
        row_pos    = '0;
        best_score = '0;
        best_class = '0;
        best_found = 1'b0;
        return keep;
    endfunction

    function automatic logic [ValueWidth-1:0] planned_value(input planned_row_t p, input int i);
        case (i)
            0: return p.cx;
            1: return p.cy;
            2: return p.w;
            3: return p.h;
            default: return (i - BoxAttrs == int'(p.peak_class)) ? p.peak : p.other;
        endcase
    endfunction

    function automatic logic [ValueWidth-1:0] pick_score();
        int pick;
        int near;
        pick = $urandom_range(0, 15);
        if (pick < 4)
        begin
            return ValueWidth'($urandom);
        end
        if (pick < 7)
        begin
            near = $urandom_range(0, 8);
            near = int'(cfg_threshold) + near - 4;
            if (near < 0) near = 0;
            if (near > 'hFFFFFF) near = 'hFFFFFF;
            return ValueWidth'(near);
        end
        if (pick == 7) return '0;
        if (pick == 8) return '1;
        return ValueWidth'($urandom_range(0, 'h3000));
    endfunction

    function automatic logic [ValueWidth-1:0] pick_attr();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 4)
        begin
            return ValueWidth'(($urandom_range(0, 1023) << 12) | $urandom_range(0, 4095));
        end
        if (pick < 6) return ValueWidth'($urandom);
        if (pick == 6) return '0;
        return '1;
    endfunction

    task automatic send_word(input logic [ValueWidth-1:0] value, input bit last,
                             input bit typed, input bit emits, input detection_t fixed);
        detection_t predicted;
        while (take_break())
        begin
            row_if.valid <= 1'b0;
            @(posedge clk);
        end
        row_if.valid      <= 1'b1;
        row_if.attr_value <= value;
        row_if.row_last   <= last;
        do @(posedge clk); while (!row_if.ready);
        if (decode_word(value, last, predicted) && !typed)
        begin
            queue_box(predicted);
        end
        if (typed && last && emits)
        begin
            queue_box(fixed);
        end
    endtask

    task automatic send_random_row(inout int sent);
        int                    words;
        int                    shape;
        logic [ValueWidth-1:0] value;
        logic [ValueWidth-1:0] prior;
        shape = $urandom_range(0, 99);
        if (shape < 10) words = $urandom_range(1, BoxAttrs);
        else if (shape < 13) words = BoxAttrs + $urandom_range(120, 140);
        else if (shape == 13) words = BoxAttrs + $urandom_range(250, 300);
        else words = BoxAttrs + $urandom_range(1, 20);
        prior = '0;
        for (int i = 0; i < words; i++)
        begin
            if (i < BoxAttrs) value = pick_attr();
            else if (i > BoxAttrs && $urandom_range(0, 7) == 0) value = prior;
            else value = pick_score();
            prior = value;
            send_word(value, i == words - 1, 1'b0, 1'b0, '0);
        end
        sent += words;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CfgDataWidth-1:0] data);
        @(posedge clk);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= data;
        case (idx)
            RegConfThreshold: cfg_threshold    = data[ValueWidth-1:0];
            RegInvScale:      cfg_inv_scale    = data[ValueWidth-1:0];
            RegPadX:          cfg_pad_x        = data[PadWidth-1:0];
            RegPadY:          cfg_pad_y        = data[PadWidth-1:0];
            RegFilterEnable:  cfg_filter       = data[0];
            RegAllowMaskLow:  cfg_allow[63:0]  = data;
            RegAllowMaskHigh: cfg_allow[127:64] = data;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [ValueWidth-1:0] threshold,
                                input logic [ValueWidth-1:0] scale,
                                input logic [PadWidth-1:0] pad_x_val,
                                input logic [PadWidth-1:0] pad_y_val,
                                input logic filter_on,
                                input logic [63:0] mask_lo,
                                input logic [63:0] mask_hi);
        write_reg(RegConfThreshold, CfgDataWidth'(threshold));
        write_reg(RegInvScale, CfgDataWidth'(scale));
        write_reg(RegPadX, CfgDataWidth'(pad_x_val));
        write_reg(RegPadY, CfgDataWidth'(pad_y_val));
        write_reg(RegFilterEnable, CfgDataWidth'(filter_on));
        write_reg(RegAllowMaskLow, mask_lo);
        write_reg(RegAllowMaskHigh, mask_hi);
        @(posedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic drain();
        row_if.valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        sink_ready <= !take_break();
        if (rst_n && box_if.valid && box_if.ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                $error("detection word with none expected: class_index %0d",
                       box_if.class_index);
                mismatches++;
            end
            else
            begin
                oldest_box = expected_boxes.pop_front();
                if (box_if.box_x !== oldest_box.box_x)
                begin
                    $error("box_x: expected %0d, got %0d", $signed(oldest_box.box_x),
                           $signed(box_if.box_x));
                    mismatches++;
                end
                if (box_if.box_y !== oldest_box.box_y)
                begin
                    $error("box_y: expected %0d, got %0d", $signed(oldest_box.box_y),
                           $signed(box_if.box_y));
                    mismatches++;
                end
                if (box_if.box_width !== oldest_box.box_width)
                begin
                    $error("box_width: expected %0d, got %0d", oldest_box.box_width,
                           box_if.box_width);
                    mismatches++;
                end
                if (box_if.box_height !== oldest_box.box_height)
                begin
                    $error("box_height: expected %0d, got %0d", oldest_box.box_height,
                           box_if.box_height);
                    mismatches++;
                end
                if (box_if.confidence !== oldest_box.confidence)
                begin
                    $error("confidence: expected %h, got %h", oldest_box.confidence,
                           box_if.confidence);
                    mismatches++;
                end
                if (box_if.class_index !== oldest_box.class_index)
                begin
                    $error("class_index: expected %0d, got %0d", oldest_box.class_index,
                           box_if.class_index);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int sent;
        row_if.valid      <= 1'b0;
        row_if.attr_value <= '0;
        row_if.row_last   <= 1'b0;
        write_enable      <= 1'b0;
        reg_index         <= RegConfThreshold;
        write_data        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NumPlanned; r++)
        begin
            for (int i = 0; i < int'(RowPlan[r].words); i++)
            begin
                send_word(planned_value(RowPlan[r], i), i == int'(RowPlan[r].words) - 1,
                          RowPlan[r].typed, RowPlan[r].emits, RowPlan[r].fixed);
            end
        end
        drain();

        for (int phase = 0; phase < NumPhases; phase++)
        begin
            case (phase)
                0: program_regs(24'd0, 24'hFFFFFF, 12'hFFF, 12'd0, 1'b0, 64'd0, 64'd0);
                1: program_regs(24'hFFFFFF, 24'd1, 12'd0, 12'hFFF, 1'b1, '1, '1);
                2: program_regs(24'($urandom_range(0, 'h2000)),
                                24'($urandom_range('h8000, 'h40000)),
                                12'($urandom_range(0, 640)), 12'($urandom_range(0, 640)),
                                1'b1, {$urandom, $urandom}, {$urandom, $urandom});
                3: program_regs(24'h800, 24'($urandom_range('h4000, 'h30000)),
                                12'($urandom_range(0, 320)), 12'($urandom_range(0, 320)),
                                1'b0, {$urandom, $urandom}, {$urandom, $urandom});
                4: program_regs(24'($urandom_range(0, 'h2000)), 24'h10000, 12'd0,
                                12'($urandom_range(0, 4095)), 1'b1, 64'd0, '1);
                default: program_regs(24'($urandom_range(0, 'h4000)),
                                      24'($urandom_range(1, 'hFFFFFF)),
                                      12'($urandom), 12'($urandom), 1'($urandom),
                                      {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            // hold both sides busy through one whole phase
            steady_run = (phase == 3);
            sent = 0;
            while (sent < PhaseWords) send_random_row(sent);
            drain();
        end

        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
